@@ rtl/core/rmsp_pkg.sv @@
// Shared types and constants for the RMSprop update pipeline.
package rmsp_pkg;

    localparam int PARAM_COUNT = 4096;
    localparam int IDX_W = $clog2(PARAM_COUNT);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 25;

    // Pipeline shape: capture, square, blend, root setup, root steps,
    // divide setup, divide steps, saturate.
    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS = 57;
    localparam int PIPE_STAGES = 6 + ROOT_STEPS + DIV_STEPS;

    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_UPDATE = 2'd1,
        OP_END    = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_BASE_RATE = 2'd0,
        CFG_DECAY     = 2'd1,
        CFG_STAB      = 2'd2,
        CFG_FORGET    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [IDX_W-1:0]   element_index;
        logic signed [31:0] old_weight;
        logic signed [31:0] gradient;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]   index_out;
        logic signed [31:0] new_weight;
    } t_out_item;

endpackage

@@ rtl/core/rmsp_stream_if.sv @@
// Valid/ready stream interface carrying one payload.
interface rmsp_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/rmsprop_parameter_update.sv @@
// 95 register stages: capture and cache read, square, blend, root setup, 32-step
// root, divide setup, 57-step divide, saturate. Throughput: one request per cycle
// while the output is not stalled and no clear pass or rate divide is running;
// the cache read-modify-write forwards. A begin step with nonzero decay runs a
// serial 41-step divide and holds intake until it ends. Reset is synchronous;
// after reset a clearing pass zeroes all 4096 cache entries and takes no request.
module rmsprop_parameter_update (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rmsp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rmsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rmsp_stream_if.sink                   s_in,
    rmsp_stream_if.source                 m_out
);
    // configuration
    logic [24:0] r_base, r_stab;
    logic [23:0] r_decay;
    logic [16:0] r_forget;
    logic [31:0] r_iter;
    logic [24:0] r_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 25'd16777; r_decay <= '0; r_stab <= 25'd2; r_forget <= 17'd58982;
        end else if (i_cfg_we) begin
            unique case (rmsp_pkg::t_cfg_idx'(i_cfg_idx))
                rmsp_pkg::CFG_BASE_RATE: r_base <= i_cfg_data;
                rmsp_pkg::CFG_DECAY:     r_decay <= i_cfg_data[23:0];
                rmsp_pkg::CFG_STAB:      r_stab <= i_cfg_data;
                rmsp_pkg::CFG_FORGET:    r_forget <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // pipeline payload
    typedef struct packed {
        logic        v;
        logic [rmsp_pkg::IDX_W-1:0] idx;
        logic signed [31:0] w;
        logic        neg;
        logic [31:0] mag;
        logic [24:0] rate;
        logic [31:0] old;
        logic [63:0] g2;
        logic [32:0] c;
        logic [63:0] rem;
        logic [63:0] rad;
        logic [32:0] root;
        logic [56:0] num;
        logic [33:0] den;
        logic [57:0] q;
        logic [58:0] dr;
    } t_stg;

    t_stg r_p [rmsp_pkg::PIPE_STAGES];
    logic stall, adv;
    assign stall = r_p[rmsp_pkg::PIPE_STAGES-1].v && !m_out.ready;
    assign adv = !stall;

    // clear pass and rate divider control
    logic [12:0] r_clr;
    logic        clearing;
    assign clearing = !r_clr[12];
    logic        r_rbusy;
    logic [5:0]  r_rcnt;
    logic [56:0] r_rrem;
    logic [40:0] r_rquo;
    logic [55:0] r_rden;
    logic        rbit;
    assign rbit = (r_rrem >> r_rcnt) >= 57'(r_rden);

    logic in_fire;
    assign s_in.ready = adv && !clearing && !r_rbusy;
    assign in_fire = s_in.valid && s_in.ready;

    // cache memory
    logic [31:0] mem [rmsp_pkg::PARAM_COUNT];
    logic [31:0] r_rd;
    logic        we;
    logic [11:0] wa;
    logic [31:0] wd;
    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        if (adv) r_rd <= mem[s_in.data.element_index];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0; r_iter <= '0; r_rate <= '0; r_rbusy <= 1'b0; r_rcnt <= '0;
        end else begin
            if (clearing) r_clr <= r_clr + 13'd1;
            if (in_fire && s_in.data.opcode == rmsp_pkg::OP_END) r_iter <= r_iter + 32'd1;
            if (in_fire && s_in.data.opcode == rmsp_pkg::OP_BEGIN) begin
                if (r_decay == '0) r_rate <= r_base;
                else begin
                    r_rbusy <= 1'b1; r_rcnt <= 6'd40;
                    r_rrem <= {16'd0, r_base, 16'd0};
                    r_rquo <= '0;
                    r_rden <= 56'd65536 + 56'(r_decay) * 56'(r_iter);
                end
            end else if (r_rbusy) begin
                // one quotient bit a cycle; load the rate with the last bit
                if (rbit) begin
                    r_rrem <= r_rrem - (57'(r_rden) << r_rcnt);
                    r_rquo[r_rcnt] <= 1'b1;
                end
                if (r_rcnt == 6'd0) begin
                    r_rbusy <= 1'b0;
                    r_rate <= {r_rquo[24:1], rbit};
                end else begin
                    r_rcnt <= r_rcnt - 6'd1;
                end
            end
        end
    end

    // stage logic
    t_stg n_p [rmsp_pkg::PIPE_STAGES];
    logic [16:0] rho;
    assign rho = (r_forget > 17'd65536) ? 17'd65536 : r_forget;

    always_comb begin
        t_stg s;
        logic [63:0] trial;
        logic [58:0] dt;
        logic [31:0] g2s;
        logic [49:0] sum;
        logic signed [35:0] nw;
        logic [33:0] st;
        for (int k = 0; k < rmsp_pkg::PIPE_STAGES; k++) n_p[k] = r_p[k];
        we = clearing; wa = r_clr[11:0]; wd = '0;
        // stage 0: capture
        s = '0;
        s.v = in_fire && s_in.data.opcode == rmsp_pkg::OP_UPDATE;
        s.idx = s_in.data.element_index; s.w = s_in.data.old_weight;
        s.neg = s_in.data.gradient[31];
        s.mag = s_in.data.gradient[31] ? 32'(-s_in.data.gradient) : s_in.data.gradient;
        s.rate = r_rate;
        n_p[0] = s;
        // stage 2: blend and write back
        s = r_p[1];
        g2s = (s.g2 > 64'hFFFFFFFF) ? 32'hFFFFFFFF : s.g2[31:0];
        sum = 50'(rho) * 50'(s.old) + 50'(17'd65536 - rho) * 50'(g2s);
        s.c = {1'b0, (sum[49:16] > 34'hFFFFFFFF) ? 32'hFFFFFFFF : sum[47:16]};
        n_p[2] = s;
        if (r_p[2].v && adv && !clearing) begin
            we = 1'b1; wa = r_p[2].idx; wd = r_p[2].c[31:0];
        end
        // stage 1: square, take read data, forward newer entries of the same index
        s = r_p[0];
        s.g2 = (64'(s.mag) * 64'(s.mag)) >> 24;
        s.old = r_rd;
        if (r_p[3].v && r_p[3].idx == s.idx) s.old = r_p[3].c[31:0];
        if (r_p[2].v && r_p[2].idx == s.idx) s.old = r_p[2].c[31:0];
        if (r_p[1].v && r_p[1].idx == s.idx) s.old = n_p[2].c[31:0];
        n_p[1] = s;
        // stage 3: root setup
        s = r_p[2];
        s.rad = {8'd0, s.c[31:0], 24'd0}; s.rem = '0; s.root = '0;
        n_p[3] = s;
        // root steps
        for (int k = 4; k < 4 + rmsp_pkg::ROOT_STEPS; k++) begin
            s = r_p[k-1];
            trial = {s.rem[61:0], s.rad[63:62]};
            if (trial >= {29'd0, s.root, 2'b01}) begin
                s.rem = trial - {29'd0, s.root, 2'b01}; s.root = {s.root[31:0], 1'b1};
            end else begin
                s.rem = trial; s.root = {s.root[31:0], 1'b0};
            end
            s.rad = s.rad << 2;
            n_p[k] = s;
        end
        // divide setup
        s = r_p[3+rmsp_pkg::ROOT_STEPS];
        s.den = 34'(s.root) + 34'(r_stab);
        if (s.den == '0) s.den = 34'd1;
        s.num = 57'(s.rate) * 57'(s.mag); s.q = '0; s.dr = '0;
        n_p[4+rmsp_pkg::ROOT_STEPS] = s;
        for (int k = 5 + rmsp_pkg::ROOT_STEPS;
             k < 5 + rmsp_pkg::ROOT_STEPS + rmsp_pkg::DIV_STEPS; k++) begin
            s = r_p[k-1];
            dt = {s.dr[57:0], s.num[56]};
            s.num = s.num << 1;
            if (dt >= 59'(s.den)) begin s.dr = dt - 59'(s.den); s.q = {s.q[56:0], 1'b1}; end
            else begin s.dr = dt; s.q = {s.q[56:0], 1'b0}; end
            n_p[k] = s;
        end
        // final: apply step and saturate
        s = r_p[rmsp_pkg::PIPE_STAGES-2];
        st = (s.q > 58'h200000000) ? 34'h200000000 : s.q[33:0];
        nw = s.neg ? 36'(s.w) + 36'(st) : 36'(s.w) - 36'(st);
        if (nw > 36'sh07FFFFFFF) s.w = 32'sh7FFFFFFF;
        else if (nw < -36'sh080000000) s.w = 32'sh80000000;
        else s.w = nw[31:0];
        n_p[rmsp_pkg::PIPE_STAGES-1] = s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rmsp_pkg::PIPE_STAGES; k++) r_p[k].v <= 1'b0;
        end else if (adv) begin
            for (int k = 0; k < rmsp_pkg::PIPE_STAGES; k++) r_p[k] <= n_p[k];
        end
    end

    assign m_out.valid = r_p[rmsp_pkg::PIPE_STAGES-1].v;
    assign m_out.data.index_out = r_p[rmsp_pkg::PIPE_STAGES-1].idx;
    assign m_out.data.new_weight = r_p[rmsp_pkg::PIPE_STAGES-1].w;

    // assertions
    a_no_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !s_in.ready) else $error("intake during clear");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |=> m_out.valid) else $error("result lost under stall");
    a_rate_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rbusy |-> !s_in.ready) else $error("intake during rate divide");
endmodule

@@ sim/rmsprop_parameter_update_tb.sv @@
// Self-checking testbench for the RMSprop parameter update block.
module rmsprop_parameter_update_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 250;

    // Predicts the updated weights and holds them until the block answers.
    class weight_scoreboard;
        logic [31:0] sq_cache [rmsp_pkg::PARAM_COUNT];
        logic [31:0] iter_cnt;
        logic [24:0] work_rate;
        logic [24:0] base_rate;
        logic [23:0] rate_decay;
        logic [24:0] stabilizer;
        logic [16:0] forget;
        rmsp_pkg::t_out_item weights_due[$];
        int          errors;

        function new();
            foreach (sq_cache[i]) sq_cache[i] = '0;
            iter_cnt = '0;
            work_rate = '0;
            base_rate = 25'd16777;
            rate_decay = '0;
            stabilizer = 25'd2;
            forget = 17'd58982;
            errors = 0;
        endfunction

        function void set_reg(rmsp_pkg::t_cfg_idx idx, logic [24:0] val);
            case (idx)
                rmsp_pkg::CFG_BASE_RATE: base_rate = val;
                rmsp_pkg::CFG_DECAY:     rate_decay = val[23:0];
                rmsp_pkg::CFG_STAB:      stabilizer = val;
                rmsp_pkg::CFG_FORGET:    forget = val[16:0];
                default: ;
            endcase
        endfunction

        // Integer square root by digit pairs.
        function longint unsigned isqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        // Note an accepted request and queue its weight, if any.
        function void note_request(rmsp_pkg::t_in_item req);
            longint unsigned mag, rho, old_c, g2, c, den, step;
            longint signed   w, g, nw;
            rmsp_pkg::t_out_item res;
            case (req.opcode)
                rmsp_pkg::OP_BEGIN: begin
                    if (rate_decay == 0) begin
                        work_rate = base_rate;
                    end else begin
                        den = 64'd65536 + longint'(rate_decay) * longint'(iter_cnt);
                        work_rate = 25'((longint'(base_rate) << 16) / den);
                    end
                end
                rmsp_pkg::OP_END: iter_cnt = iter_cnt + 1;
                rmsp_pkg::OP_UPDATE: begin
                    w = longint'(req.old_weight);
                    g = longint'(req.gradient);
                    mag = (g < 0) ? -g : g;
                    rho = (forget > 17'd65536) ? 64'd65536 : forget;
                    old_c = sq_cache[req.element_index];
                    g2 = (mag * mag) >> 24;
                    if (g2 > 64'hFFFF_FFFF) g2 = 64'hFFFF_FFFF;
                    c = (rho * old_c + (64'd65536 - rho) * g2) >> 16;
                    if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
                    sq_cache[req.element_index] = c[31:0];
                    den = isqrt(c << 24) + stabilizer;
                    if (den == 0) den = 1;
                    step = (longint'(work_rate) * mag) / den;
                    if (step > (64'd1 << 33)) step = 64'd1 << 33;
                    nw = (g < 0) ? w + longint'(step) : w - longint'(step);
                    if (nw > 64'sd2147483647) nw = 64'sd2147483647;
                    if (nw < -64'sd2147483648) nw = -64'sd2147483648;
                    res.index_out = req.element_index;
                    res.new_weight = nw[31:0];
                    weights_due = {weights_due, res};
                end
                default: ;
            endcase
        endfunction

        // Compare one result with the oldest queued weight.
        function void check_result(rmsp_pkg::t_out_item got);
            rmsp_pkg::t_out_item want;
            if (weights_due.size() == 0) begin
                $display("%0t: unexpected result index %0d weight %0d",
                         $time, got.index_out, got.new_weight);
                errors++;
                return;
            end
            want = weights_due.pop_front();
            if (got.index_out !== want.index_out) begin
                $display("%0t: index_out expected %0d actual %0d",
                         $time, want.index_out, got.index_out);
                errors++;
            end
            if (got.new_weight !== want.new_weight) begin
                $display("%0t: new_weight expected %0d actual %0d",
                         $time, want.new_weight, got.new_weight);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [rmsp_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [rmsp_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    rmsp_stream_if #(.T(rmsp_pkg::t_in_item))  req_if ();
    rmsp_stream_if #(.T(rmsp_pkg::t_out_item)) res_if ();

    weight_scoreboard sb;
    bit   steady = 1'b0;
    int   quiet_cycles = 0;
    logic [11:0] hot_idx [16];

    rmsprop_parameter_update uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (req_if.sink),
        .m_out      (res_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.data = '0;
        res_if.ready = 1'b0;
        sb = new();
    end

    // Stall the result side at random, except while steady is set.
    always @(negedge i_clk) begin
        res_if.ready <= steady ? 1'b1 : ($urandom_range(99) >= 29);
    end

    // Note accepted requests, check results, watch for a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) sb.note_request(req_if.data);
            if (res_if.valid && res_if.ready) sb.check_result(res_if.data);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[rmsprop_parameter_update] ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(rmsp_pkg::t_cfg_idx idx, logic [24:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Drain all pending weights, then let the pipeline settle.
    task automatic wait_idle();
        while (sb.weights_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Send one request with a random gap ahead of it unless steady is set.
    task automatic send(logic [1:0] op, logic [11:0] idx,
                        logic [31:0] w, logic [31:0] g);
        rmsp_pkg::t_in_item req;
        req.opcode = op;
        req.element_index = idx;
        req.old_weight = w;
        req.gradient = g;
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 29) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.data = req;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic release_bus();
        @(negedge i_clk);
        req_if.valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_gradient();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3, 4: return 32'($urandom_range(33554432)) - 32'd16777216;
            5:       return 32'($urandom_range(65535)) - 32'd32768;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [11:0] pick_index();
        if ($urandom_range(99) < 70) return hot_idx[$urandom_range(15)];
        return 12'($urandom);
    endfunction

    // One training step with random content, sometimes broken up.
    task automatic random_step(ref int sent);
        int n;
        n = $urandom_range(40, 1);
        if ($urandom_range(9) != 0)
            send(rmsp_pkg::OP_BEGIN, 12'($urandom), $urandom, $urandom);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(19))
                0:       send(rmsp_pkg::OP_NONE, 12'($urandom), $urandom, $urandom);
                1:       send(rmsp_pkg::OP_END, 12'($urandom), $urandom, $urandom);
                default: send(rmsp_pkg::OP_UPDATE, pick_index(), $urandom, pick_gradient());
            endcase
            sent++;
        end
        if ($urandom_range(9) != 0)
            send(rmsp_pkg::OP_END, 12'($urandom), $urandom, $urandom);
        sent += 2;
    endtask

    // Register settings per phase: base rate, decay, stabilizer, forget factor.
    logic [24:0] phase_cfg [6][4] = '{
        '{25'd16777,    25'd0,        25'd2,        25'd58982},
        '{25'd16777216, 25'd0,        25'd0,        25'd65536},
        '{25'h1FF_FFFF, 25'hFF_FFFF,  25'd16777216, 25'd0},
        '{25'd8388608,  25'd65536,    25'd1,        25'h1_FFFF},
        '{25'd1000000,  25'd300,      25'd2000,     25'd58982},
        '{25'd0,        25'd1,        25'd2,        25'd32768}
    };

    initial begin
        int sent;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: update before any begin step, extremes, ignored opcode.
        send(rmsp_pkg::OP_UPDATE, 12'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        send(rmsp_pkg::OP_UPDATE, 12'd4095, 32'h8000_0000, 32'h7FFF_FFFF);
        send(rmsp_pkg::OP_NONE, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(rmsp_pkg::OP_BEGIN, 12'd0, 32'd0, 32'd0);
        send(rmsp_pkg::OP_UPDATE, 12'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        send(rmsp_pkg::OP_UPDATE, 12'd4095, 32'h8000_0000, 32'h7FFF_FFFF);
        send(rmsp_pkg::OP_UPDATE, 12'd1, 32'd0, 32'd0);
        send(rmsp_pkg::OP_UPDATE, 12'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(rmsp_pkg::OP_UPDATE, 12'd2, 32'h0100_0000, 32'h0100_0000);
        send(rmsp_pkg::OP_UPDATE, 12'd0, 32'h0, 32'h0000_0001);
        send(rmsp_pkg::OP_END, 12'd0, 32'd0, 32'd0);
        send(rmsp_pkg::OP_NONE, 12'd0, 32'd0, 32'd0);
        release_bus();
        wait_idle();

        sent = 0;
        for (int p = 0; p < 6; p++) begin
            write_reg(rmsp_pkg::CFG_BASE_RATE, phase_cfg[p][0]);
            write_reg(rmsp_pkg::CFG_DECAY, phase_cfg[p][1]);
            write_reg(rmsp_pkg::CFG_STAB, phase_cfg[p][2]);
            write_reg(rmsp_pkg::CFG_FORGET, phase_cfg[p][3]);
            foreach (hot_idx[i]) hot_idx[i] = 12'($urandom);
            // A zero gradient on zero cache with zero stabilizer hits the zero
            // denominator path.
            send(rmsp_pkg::OP_BEGIN, 12'd0, 32'd0, 32'd0);
            send(rmsp_pkg::OP_UPDATE, 12'($urandom), $urandom, 32'd0);
            steady = (p == 2);
            while (sent < (p + 1) * 258) random_step(sent);
            steady = 1'b0;
            release_bus();
            wait_idle();
        end

        if (sb.errors == 0)
            $display("[rmsprop_parameter_update] OK");
        else
            $display("[rmsprop_parameter_update] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/rmsp_pkg.sv
rtl/core/rmsp_stream_if.sv
rtl/core/rmsprop_parameter_update.sv
sim/rmsprop_parameter_update_tb.sv
